// ===== hdl/packbits_style_rle_decoder_core_defines.svh =====
// assertion macros for the run-length decoder core
`ifndef PACKBITS_STYLE_RLE_DECODER_CORE_DEFINES_SVH
`define PACKBITS_STYLE_RLE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PBRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PBRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pbrle_pkg.sv =====
// shared types and constants for the run-length decoder core
package pbrle_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 1048576;
    localparam int unsigned TOTAL_W        = 21;
    localparam int unsigned CFG_DATA_W     = 21;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE = 1'd1;

    localparam logic [TOTAL_W-1:0] PIXEL_TOTAL_RST = 21'd65536;

    localparam logic [7:0] CODE_NOP = 8'h80;
    localparam logic [8:0] REP_BASE = 9'h101;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] run_length;
        logic       opaque;
        logic       image_done;
        logic       overflow_error;
    } out_item_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] run_length;
        logic       image_done;
        logic       overflow_error;
    } run_cmd_t;

endpackage

// ===== hdl/pbrle_front.sv =====
// front end: config registers, code parsing and run bookkeeping
module pbrle_front #(
    parameter int unsigned MAX_PIXELS = pbrle_pkg::MAX_PIXELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pbrle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              accept,
    input  pbrle_pkg::in_item_t               item,
    output logic                              push,
    output pbrle_pkg::run_cmd_t               cmd
);

    localparam int unsigned PIX_W = $clog2(MAX_PIXELS + 1);
    localparam int unsigned CMP_W = (PIX_W > pbrle_pkg::TOTAL_W) ? PIX_W : pbrle_pkg::TOTAL_W;

    localparam logic [1:0] PH_CODE = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_REP  = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    logic [pbrle_pkg::TOTAL_W-1:0] pixel_total_reg;
    logic                          strict_mode_reg;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       lit_left_reg, lit_left_next;
    logic [7:0]       rep_cnt_reg, rep_cnt_next;
    logic [PIX_W-1:0] pix_left_reg, pix_left_next;

    logic [CMP_W-1:0] total_ext;
    logic [CMP_W-1:0] max_ext;
    logic [PIX_W-1:0] total_sat;
    logic [1:0]       ph;
    logic [7:0]       ll;
    logic [7:0]       rc;
    logic [PIX_W-1:0] pl;
    logic [7:0]       len;
    logic [PIX_W-1:0] len_ext;
    logic [PIX_W-1:0] rc_ext;
    logic [7:0]       rep_len;
    logic [PIX_W-1:0] pl_lit;
    logic [PIX_W-1:0] pl_rep;
    logic [7:0]       ll_dec;
    logic             has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg <= pbrle_pkg::PIXEL_TOTAL_RST;
            strict_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pbrle_pkg::REG_PIXEL_TOTAL: pixel_total_reg <= cfg_data;
                pbrle_pkg::REG_STRICT_MODE: strict_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        total_ext = CMP_W'(pixel_total_reg);
        max_ext   = CMP_W'(MAX_PIXELS);
        total_sat = (total_ext > max_ext) ? max_ext[PIX_W-1:0] : total_ext[PIX_W-1:0];

        if (item.first)
        begin
            pl = total_sat;
            ll = 8'd0;
            rc = 8'd0;
            ph = (total_sat == '0) ? PH_HALT : PH_CODE;
        end
        else
        begin
            pl = pix_left_reg;
            ll = lit_left_reg;
            rc = rep_cnt_reg;
            ph = phase_reg;
        end

        len     = (item.code_byte < 8'h80) ? (item.code_byte + 8'd1)
                                           : 8'(pbrle_pkg::REP_BASE - {1'b0, item.code_byte});
        len_ext = PIX_W'(len);
        rc_ext  = PIX_W'(rc);
        rep_len = (rc_ext > pl) ? pl[7:0] : rc;
        pl_lit  = pl - PIX_W'(1);
        pl_rep  = pl - PIX_W'(rep_len);
        ll_dec  = (ll != 8'd0) ? (ll - 8'd1) : 8'd0;

        phase_next    = ph;
        lit_left_next = ll;
        rep_cnt_next  = rc;
        pix_left_next = pl;
        has_result    = 1'b0;
        cmd           = '0;

        if (ph != PH_HALT && pl != '0)
        begin
            case (ph)
                PH_CODE:
                begin
                    if (item.code_byte != pbrle_pkg::CODE_NOP)
                    begin
                        if (strict_mode_reg && (len_ext > pl))
                        begin
                            phase_next         = PH_HALT;
                            has_result         = 1'b1;
                            cmd.overflow_error = 1'b1;
                        end
                        else if (item.code_byte < 8'h80)
                        begin
                            lit_left_next = len;
                            phase_next    = PH_LIT;
                        end
                        else
                        begin
                            rep_cnt_next = len;
                            phase_next   = PH_REP;
                        end
                    end
                end
                PH_LIT:
                begin
                    has_result      = 1'b1;
                    pix_left_next   = pl_lit;
                    lit_left_next   = ll_dec;
                    cmd.pixel_value = item.code_byte;
                    cmd.run_length  = 8'd1;
                    if (pl_lit == '0)
                    begin
                        phase_next     = PH_HALT;
                        lit_left_next  = 8'd0;
                        cmd.image_done = 1'b1;
                    end
                    else if (ll_dec == 8'd0)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_REP:
                begin
                    has_result      = 1'b1;
                    pix_left_next   = pl_rep;
                    rep_cnt_next    = 8'd0;
                    cmd.pixel_value = item.code_byte;
                    cmd.run_length  = rep_len;
                    if (pl_rep == '0)
                    begin
                        phase_next     = PH_HALT;
                        cmd.image_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
                default: ;
            endcase
        end

        push = accept && has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CODE;
            lit_left_reg <= 8'd0;
            rep_cnt_reg  <= 8'd0;
            pix_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_cnt_reg  <= rep_cnt_next;
            pix_left_reg <= pix_left_next;
        end
    end

endmodule

// ===== hdl/pbrle_queue.sv =====
// short command queue between front end and back end
module pbrle_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pbrle_pkg::run_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output pbrle_pkg::run_cmd_t  head_cmd
);

    localparam int unsigned DEPTH = pbrle_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pbrle_pkg::run_cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        not_empty = (count_reg != '0);
        head_cmd  = entry_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end

        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pbrle_back.sv =====
// back end: formats queued runs into the output register
module pbrle_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  pbrle_pkg::run_cmd_t  cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pbrle_pkg::out_item_t out_data
);

    logic                  out_valid_reg, out_valid_next;
    pbrle_pkg::out_item_t  out_data_reg;

    always_comb
    begin
        pop            = cmd_valid && (!out_valid_reg || out_ready);
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg.pixel_value    <= cmd.pixel_value;
            out_data_reg.run_length     <= cmd.run_length;
            out_data_reg.opaque         <= (cmd.pixel_value != 8'd0);
            out_data_reg.image_done     <= cmd.image_done;
            out_data_reg.overflow_error <= cmd.overflow_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/packbits_style_rle_decoder_core.sv =====
// top level of the run-length decoder core
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data (code_byte, first)
//  out      output     out_valid / out_ready  out_data (run result)
//  cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; the front end updates run state in the transfer cycle
// a result is written to the queue at its byte transfer edge and loaded into the
// output register once that register is empty or out_ready is high, which raises out_valid
// reset: pixel_total 65536, strict_mode 0, no image active until a first byte
// in_ready drops only when the two-entry queue is full under output stall
`include "packbits_style_rle_decoder_core_defines.svh"
module packbits_style_rle_decoder_core #(
    parameter int unsigned MAX_PIXELS = pbrle_pkg::MAX_PIXELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pbrle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pbrle_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pbrle_pkg::out_item_t              out_data
);

    logic                 accept;
    logic                 push;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 pop;
    pbrle_pkg::run_cmd_t  front_cmd;
    pbrle_pkg::run_cmd_t  head_cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    pbrle_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_data),
        .push      (push),
        .cmd       (front_cmd)
    );

    pbrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    pbrle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `PBRLE_ASSERT_NOW(a_err_shape, clk, rst_n,
        out_valid && out_data.overflow_error,
        out_data.run_length == 8'd0 && !out_data.image_done && !out_data.opaque,
        "error result carries a run")
    `PBRLE_ASSERT_NOW(a_run_nonzero, clk, rst_n,
        out_valid && !out_data.overflow_error,
        out_data.run_length != 8'd0,
        "pixel result with zero length")
    `PBRLE_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !q_full, "queue push while full")
    `PBRLE_ASSERT_NEXT(a_pop_loads, clk, rst_n, pop, out_valid, "popped run not presented")

endmodule
